FILE: hdl/wsalu_pkg.sv
`timescale 1ns / 1ps
package wsalu_pkg;

    localparam int DATA_W          = 64;
    localparam int HALF_W          = DATA_W / 2;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [3:0] {
        ACT_ADD  = 4'd0,
        ACT_SUB  = 4'd1,
        ACT_MUL  = 4'd2,
        ACT_DIV  = 4'd3,
        ACT_MOD  = 4'd4,
        ACT_SHL  = 4'd5,
        ACT_SHR  = 4'd6,
        ACT_NOTA = 4'd7,
        ACT_NOTB = 4'd8,
        ACT_AND  = 4'd9,
        ACT_OR   = 4'd10,
        ACT_XOR  = 4'd11
    } t_action;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_64 = 2'd3
    } t_width;

    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2,
        CLS_DIVZ   = 2'd3
    } t_op_class;

    typedef struct packed {
        logic [3:0]        action;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              divide_by_zero;
    } t_out;

    typedef struct packed {
        logic [3:0]        action;
        t_op_class         cls;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [DATA_W-1:0] width_max(input logic [1:0] mode);
        logic [DATA_W-1:0] m;
        case (mode)
            WIDTH_8:  m = DATA_W'(64'hFF);
            WIDTH_16: m = DATA_W'(64'hFFFF);
            WIDTH_32: m = DATA_W'(64'hFFFF_FFFF);
            default:  m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] clamp(input logic [DATA_W-1:0] v,
                                                input logic [1:0] mode);
        logic [DATA_W-1:0] m;
        m = width_max(mode);
        return (v > m) ? m : v;
    endfunction

endpackage

FILE: hdl/wsalu_front.sv
`timescale 1ns / 1ps
module wsalu_front (
    input  logic            i_start,
    input  logic            i_full,
    input  logic [1:0]      i_width_mode,
    input  wsalu_pkg::t_in  i_in,
    output logic            o_push,
    output wsalu_pkg::t_entry o_entry
);
    import wsalu_pkg::*;

    logic [DATA_W-1:0] a_sat;
    logic [DATA_W-1:0] b_sat;

    always_comb begin
        a_sat  = clamp(i_in.operand_a, i_width_mode);
        b_sat  = clamp(i_in.operand_b, i_width_mode);
        o_push = i_start && !i_full;
        o_entry.action = i_in.action;
        o_entry.a      = a_sat;
        o_entry.b      = b_sat;
        case (i_in.action)
            ACT_MUL: begin
                o_entry.cls = CLS_MUL;
            end
            ACT_DIV, ACT_MOD: begin
                o_entry.cls = (b_sat == '0) ? CLS_DIVZ : CLS_DIV;
            end
            default: begin
                o_entry.cls = CLS_SIMPLE;
            end
        endcase
    end

endmodule

FILE: hdl/wsalu_queue.sv
`timescale 1ns / 1ps
module wsalu_queue #(
    parameter int DEPTH = wsalu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsalu_pkg::t_entry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output wsalu_pkg::t_entry o_entry
);
    import wsalu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

FILE: hdl/wsalu_div.sv
`timescale 1ns / 1ps
module wsalu_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wsalu_pkg::DATA_W-1:0]   i_dividend,
    input  logic [wsalu_pkg::DATA_W-1:0]   i_divisor,
    output wsalu_pkg::t_div_stat           o_stat,
    output logic [wsalu_pkg::DATA_W-1:0]   o_quotient,
    output logic [wsalu_pkg::DATA_W-1:0]   o_remainder
);
    import wsalu_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic               r_busy, r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DATA_W-1:0]  r_rem, r_quo, r_dvs;
    logic [DATA_W:0]    trial;
    logic               fits;

    // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
    always_comb begin
        trial = {r_rem, r_quo[DATA_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DATA_W'(trial - {1'b0, r_dvs}) : trial[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], fits};
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

FILE: hdl/wsalu_back.sv
`timescale 1ns / 1ps
module wsalu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_width_mode,
    input  logic              i_q_valid,
    input  wsalu_pkg::t_entry i_q_entry,
    output logic              o_pop,
    output logic              o_valid,
    output wsalu_pkg::t_out   o_out
);
    import wsalu_pkg::*;

    t_entry            r_s1;
    logic              r_s1_valid;
    logic              r_s2_valid, r_s2_is_mul, r_s2_dz;
    logic [DATA_W-1:0] r_s2_val;
    logic [HALF_W-1:0] r_s2_p1, r_s2_p2;
    logic              r_out_valid;
    t_out              r_out;

    t_div_stat         div_stat;
    logic [DATA_W-1:0] div_quo, div_rem;
    logic              s1_needs_div, div_start, s1_adv;
    logic [DATA_W-1:0] s1_val;
    logic              s1_big_shift;
    logic [DATA_W-1:0] mul_full;

    wsalu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_s1.a),
        .i_divisor   (r_s1.b),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // A divide holds stage one until the divider reports done; all else moves every cycle.
    always_comb begin
        s1_needs_div = r_s1_valid && (r_s1.cls == CLS_DIV);
        div_start    = s1_needs_div && !div_stat.busy && !div_stat.done;
        s1_adv       = r_s1_valid && (!s1_needs_div || div_stat.done);
        o_pop        = i_q_valid && (!r_s1_valid || s1_adv);
        s1_big_shift = (r_s1.b[DATA_W-1:6] != '0);
        case (r_s1.action)
            ACT_ADD:  s1_val = r_s1.a + r_s1.b;
            ACT_SUB:  s1_val = r_s1.a - r_s1.b;
            ACT_MUL:  s1_val = r_s1.a[HALF_W-1:0] * r_s1.b[HALF_W-1:0];
            ACT_DIV:  s1_val = (r_s1.cls == CLS_DIVZ) ? '0 : div_quo;
            ACT_MOD:  s1_val = (r_s1.cls == CLS_DIVZ) ? '0 : div_rem;
            ACT_SHL:  s1_val = s1_big_shift ? '0 : (r_s1.a << r_s1.b[5:0]);
            ACT_SHR:  s1_val = s1_big_shift ? '0 : (r_s1.a >> r_s1.b[5:0]);
            ACT_NOTA: s1_val = ~r_s1.a;
            ACT_NOTB: s1_val = ~r_s1.b;
            ACT_AND:  s1_val = r_s1.a & r_s1.b;
            ACT_OR:   s1_val = r_s1.a | r_s1.b;
            ACT_XOR:  s1_val = r_s1.a ^ r_s1.b;
            default:  s1_val = '0;
        endcase
    end

    always_comb begin
        mul_full = r_s2_val + {HALF_W'(r_s2_p1 + r_s2_p2), {HALF_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            r_s2_valid  <= s1_adv;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_q_entry;
        end
        if (s1_adv) begin
            r_s2_is_mul <= (r_s1.cls == CLS_MUL);
            r_s2_dz     <= (r_s1.cls == CLS_DIVZ);
            r_s2_val    <= s1_val;
            r_s2_p1     <= HALF_W'(r_s1.a[HALF_W-1:0] * r_s1.b[DATA_W-1:HALF_W]);
            r_s2_p2     <= HALF_W'(r_s1.a[DATA_W-1:HALF_W] * r_s1.b[HALF_W-1:0]);
        end
        r_out.result         <= clamp(r_s2_is_mul ? mul_full : r_s2_val, i_width_mode);
        r_out.divide_by_zero <= r_s2_dz;
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.divide_by_zero) |-> (o_out.result == '0))
        else $error("divide by zero with nonzero result");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_stat.busy && r_s1_valid) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stage one changed while divider busy");
    a_div_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_s1.action == ACT_DIV || r_s1.action == ACT_MOD))
        else $error("divider started for a non-divide");

endmodule

FILE: hdl/width_saturating_integer_alu.sv
`timescale 1ns / 1ps
// Unsigned integer ALU with selectable width (8, 16, 32 or 64 bits).
// Input: an operation beat is taken at a rising edge where start is high and
// busy is low. Operands are saturated to the width maximum on entry and put
// in a small queue; the execute pipeline drains that queue in order.
// Output: each result is shown for exactly one cycle with o_valid high; the
// receiver cannot stall, so results never back up into the pipeline.
// An accepted beat passes through the queue, stage one, stage two and the output
// register; a divide or modulo with nonzero divisor also waits in stage one for
// the one-bit-per-cycle divider. Throughput is one beat per cycle while busy is
// low and no divide holds the pipe head; busy rises once the queue fills.
// Multiply uses three 32x32 partial products, combined one stage later.
// Configuration: i_cfg_we writes i_cfg_wdata to the width mode (3 = 64 bit
// after reset); write it only while no operation is in flight.
// Reset clears the queue and all pipeline valid bits.
module width_saturating_integer_alu #(
    parameter int QUEUE_DEPTH = wsalu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  wsalu_pkg::t_in  i_in,
    output logic            o_valid,
    output wsalu_pkg::t_out o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_wdata
);
    import wsalu_pkg::*;

    logic [1:0] r_width_mode;
    logic       q_full, q_valid, push, pop;
    t_entry     push_entry, head_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_mode <= WIDTH_64;
        end else if (i_cfg_we) begin
            r_width_mode <= i_cfg_wdata;
        end
    end

    assign busy = q_full;

    wsalu_front u_front (
        .i_start      (start),
        .i_full       (q_full),
        .i_width_mode (r_width_mode),
        .i_in         (i_in),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    wsalu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    wsalu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width_mode (r_width_mode),
        .i_q_valid    (q_valid),
        .i_q_entry    (head_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_out        (o_out)
    );

endmodule

FILE: dv/tb_width_saturating_integer_alu.sv
`timescale 1ns / 1ps
module tb_width_saturating_integer_alu;
    import wsalu_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    t_in        op_beat;
    logic       res_valid;
    t_out       res_beat;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    width_saturating_integer_alu u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (op_beat),
        .o_valid    (res_valid),
        .o_out      (res_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    t_out       alu_expect_q[$];
    logic [1:0] width_sel;
    int         mismatch_cnt;
    int         idle_pct;
    int         wd_cnt;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [63:0] sat_to_width(logic [63:0] v, logic [1:0] w);
        logic [63:0] m;
        case (w)
            WIDTH_8:  m = 64'hFF;
            WIDTH_16: m = 64'hFFFF;
            WIDTH_32: m = 64'hFFFF_FFFF;
            default:  m = '1;
        endcase
        return (v > m) ? m : v;
    endfunction

    function automatic t_out alu_compute(t_in op, logic [1:0] w);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        t_out        o;
        a = sat_to_width(op.operand_a, w);
        b = sat_to_width(op.operand_b, w);
        r = '0;
        o.divide_by_zero = 1'b0;
        case (op.action)
            ACT_ADD:  r = a + b;
            ACT_SUB:  r = a - b;
            ACT_MUL:  r = a * b;
            ACT_DIV:  if (b != 0) r = a / b; else o.divide_by_zero = 1'b1;
            ACT_MOD:  if (b != 0) r = a % b; else o.divide_by_zero = 1'b1;
            ACT_SHL:  r = (b < 64) ? (a << b[5:0]) : '0;
            ACT_SHR:  r = (b < 64) ? (a >> b[5:0]) : '0;
            ACT_NOTA: r = ~a;
            ACT_NOTB: r = ~b;
            ACT_AND:  r = a & b;
            ACT_OR:   r = a | b;
            ACT_XOR:  r = a ^ b;
            default:  r = '0;
        endcase
        o.result = sat_to_width(r, w);
        return o;
    endfunction

    // Result checker: every strobed beat must match the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && res_valid) begin
            if (alu_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result %h dz %b", res_beat.result,
                             res_beat.divide_by_zero);
            end else begin
                t_out e;
                e = alu_expect_q.pop_front();
                if (e.result !== res_beat.result ||
                    e.divide_by_zero !== res_beat.divide_by_zero) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %h dz %b, got %h dz %b", e.result,
                                 e.divide_by_zero, res_beat.result,
                                 res_beat.divide_by_zero);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || res_valid || (start && !busy)) wd_cnt <= 0;
        else wd_cnt <= wd_cnt + 1;
        if (wd_cnt >= WATCHDOG_LIMIT) begin
            $display("width_saturating_integer_alu verification failed");
            $finish;
        end
    end

    // Start stays high after a beat is taken so that the next call can follow at once.
    task automatic send_op(t_action act, logic [63:0] a, logic [63:0] b);
        t_in op;
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        op.action    = act;
        op.operand_a = a;
        op.operand_b = b;
        start   <= 1'b1;
        op_beat <= op;
        @(posedge clk);
        while (busy) @(posedge clk);
        alu_expect_q.push_back(alu_compute(op, width_sel));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (alu_expect_q.size() != 0) @(posedge clk);
        // A divide may still be in flight only if a checker lost its beat.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(logic [1:0] w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_sel = w;
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5, 0))
            0: v = v & 64'hFF;
            1: v = v & 64'hFFFF;
            2: v = v & 64'hFFFF_FFFF;
            3: v = 64'($urandom_range(70, 0));
            4: v = ($urandom_range(1, 0) != 0) ? '1 : '0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed_extremes();
        t_action act;
        idle_pct = 0;
        for (int i = 0; i <= ACT_XOR; i++) begin
            act = t_action'(i);
            send_op(act, '1, '1);
        end
        send_op(ACT_DIV, 64'd100, '0);
        send_op(ACT_MOD, 64'd100, '0);
        send_op(ACT_SHL, 64'h1, 64'd64);
        send_op(ACT_SHR, '1, 64'd200);
        send_op(ACT_SHL, 64'h1, 64'd63);
        send_op(ACT_SUB, 64'd1, 64'd2);
        send_op(ACT_ADD, '0, '0);
        send_op(ACT_MUL, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
    endtask

    task automatic test_underflow_narrow();
        set_width(WIDTH_8);
        send_op(ACT_SUB, 64'd3, 64'd5);
        send_op(ACT_ADD, 64'h1FF, 64'd1);
        send_op(ACT_NOTA, 64'd0, 64'd0);
        send_op(ACT_SHL, 64'd1, 64'd8);
        send_op(ACT_DIV, 64'd9, 64'd0);
    endtask

    task automatic test_random_phase(int n, int pct);
        t_action act;
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            // Divides are slow, so keep them a small share of the mix.
            act = t_action'($urandom_range(ACT_XOR, 0));
            if ((act == ACT_DIV || act == ACT_MOD) && $urandom_range(2, 0) != 0)
                act = ACT_XOR;
            send_op(act, rand_operand(), rand_operand());
        end
    endtask

    task automatic test_random_widths();
        logic [1:0] order[4] = '{WIDTH_64, WIDTH_16, WIDTH_32, WIDTH_8};
        int         pcts[4] = '{0, 71, 13, 0};
        for (int p = 0; p < 4; p++) begin
            set_width(order[p]);
            test_random_phase(130, pcts[p]);
            // Hold off until everything in flight has returned.
            wait_drained();
            test_random_phase(8, 0);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        start        = 1'b0;
        op_beat      = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        width_sel    = WIDTH_64;
        mismatch_cnt = 0;
        idle_pct     = 0;
        wd_cnt       = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_underflow_narrow();
        test_random_widths();
        wait_drained();
        if (mismatch_cnt == 0 && alu_expect_q.size() == 0)
            $display("width_saturating_integer_alu verification clean");
        else
            $display("width_saturating_integer_alu verification failed");
        $finish;
    end

endmodule
